[rtl/core/assert_macros.svh]
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/fbrq_pkg.sv]
package fbrq_pkg;

    localparam int RingDepth     = 256;
    localparam int MaxFrameBytes = 64;
    localparam int HeaderBytes   = 3;
    localparam int PayloadMax    = MaxFrameBytes - HeaderBytes;
    localparam int PtrW          = $clog2(RingDepth);
    localparam int LenW          = $clog2(RingDepth + 1);
    localparam int StgW          = $clog2(PayloadMax + 1);
    localparam int StgAw         = $clog2(PayloadMax);

    localparam logic [1:0] CFG_FIRST_MARK  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MARK = 2'd1;
    localparam logic [1:0] CFG_RING_LENGTH = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_LEN_ERR = 3'd2;
    localparam logic [2:0] ST_NOSPACE = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_NOITEM  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COMMIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_STATUS
    } t_state;

    typedef enum logic [1:0] {
        H_HUNT,
        H_MARK1,
        H_MARK2,
        H_BODY
    } t_hunt;

    typedef struct packed {
        logic            wr_en;
        logic [PtrW-1:0] addr;
        logic [7:0]      wdata;
    } t_ring_req;

endpackage

[rtl/core/fbrq_ring_ram.sv]
module fbrq_ring_ram (
    input  logic                      i_clk,
    input  fbrq_pkg::t_ring_req       i_req,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [fbrq_pkg::RingDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

[rtl/core/fbrq_stage_ram.sv]
module fbrq_stage_ram (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [fbrq_pkg::StgAw-1:0]       i_addr,
    input  logic [7:0]                       i_wdata,
    output logic [7:0]                       o_rdata
);

    logic [7:0] r_mem [fbrq_pkg::PayloadMax];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

[rtl/core/framed_byte_ring_queue.sv]
// Channel   | Handshake            | Payload
// input     | i_valid / o_ready    | i_req_type, i_data_byte, i_last_byte
// result    | o_valid / i_ready    | o_out_byte, o_out_last, o_status, o_used_bytes
// config    | i_cfg_we             | i_cfg_index, i_cfg_data
// A staged push beat writes its byte to the staging RAM; a committing push writes
// each frame byte to the ring in COMMIT, then STATUS registers its result beat.
// A pop reads each scanned ring byte in SCAN_RD and checks it in SCAN_CHK, as the ring
// port read is registered; each payload byte is then re-read from the ring per beat.
// Reset is synchronous and empties the queue; the ring memory is not cleared.
// A stalled result beat holds the sequencer; no new beat is taken until it drains.
`include "assert_macros.svh"

module framed_byte_ring_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_status,
    output logic [8:0]  o_used_bytes,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int PW = fbrq_pkg::PtrW;
    localparam int LW = fbrq_pkg::LenW;
    localparam int SW = fbrq_pkg::StgW;

    fbrq_pkg::t_state r_state, n_state;
    fbrq_pkg::t_hunt  r_hunt, n_hunt;

    logic [7:0]    r_mark1, r_mark2;
    logic [LW-1:0] r_rlen;
    logic [PW-1:0] r_rd, n_rd, r_wr, n_wr;
    logic          r_full, n_full;
    logic [SW-1:0] r_scnt, n_scnt;
    logic          r_sovf, n_sovf;
    logic [LW-1:0] r_left, n_left;
    logic [SW-1:0] r_want, n_want, r_got, n_got;
    logic [SW+1:0] r_idx, n_idx;
    logic [SW+1:0] r_total;
    logic [PW-1:0] r_pstart, n_pstart;
    logic [PW-1:0] r_eptr, n_eptr;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_olast, n_olast;
    logic [2:0]    r_ostat, n_ostat;
    logic [LW-1:0] r_oused, n_oused;

    fbrq_pkg::t_ring_req ring_req;
    logic [7:0] ring_rdata, stage_rdata;
    logic       stage_we;
    logic [fbrq_pkg::StgAw-1:0] stage_addr;

    logic [LW-1:0] used_now;
    logic [LW:0]   diff;
    logic          accept;
    logic [8:0]    cfg_len;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p, input logic [LW-1:0] len);
        logic [LW-1:0] q;
        q = {1'b0, p} + LW'(1);
        return (q >= len) ? '0 : q[PW-1:0];
    endfunction

    always_comb begin
        diff = {2'b0, r_wr} + {1'b0, r_rlen} - {2'b0, r_rd};
        if (r_full) begin
            used_now = r_rlen;
        end else if (diff >= {1'b0, r_rlen}) begin
            used_now = LW'(diff - {1'b0, r_rlen});
        end else begin
            used_now = diff[LW-1:0];
        end
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == fbrq_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_out_last = r_olast;
    assign o_status   = r_ostat;
    assign o_used_bytes = 9'(r_oused);

    fbrq_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    fbrq_stage_ram u_stage (
        .i_clk   (i_clk),
        .i_wr_en (stage_we),
        .i_addr  (stage_addr),
        .i_wdata (i_data_byte),
        .o_rdata (stage_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbrq_pkg::S_IDLE: begin
                if (accept && i_req_type) begin
                    if (!r_full && r_wr == r_rd) begin
                        n_state = fbrq_pkg::S_STATUS;
                    end else begin
                        n_state = fbrq_pkg::S_SCAN_RD;
                    end
                end else if (accept && i_last_byte) begin
                    n_state = fbrq_pkg::S_COMMIT;
                end
            end
            fbrq_pkg::S_COMMIT: begin
                if (r_idx == r_total || r_ostat != fbrq_pkg::ST_OK) begin
                    n_state = fbrq_pkg::S_STATUS;
                end
            end
            fbrq_pkg::S_SCAN_RD:  n_state = fbrq_pkg::S_SCAN_CHK;
            fbrq_pkg::S_SCAN_CHK: begin
                if (r_hunt == fbrq_pkg::H_BODY && r_got + SW'(1) == r_want) begin
                    n_state = fbrq_pkg::S_EMIT_RD;
                end else if (r_left == LW'(1)) begin
                    n_state = fbrq_pkg::S_STATUS;
                end else begin
                    n_state = fbrq_pkg::S_SCAN_RD;
                end
            end
            fbrq_pkg::S_EMIT_RD:  n_state = fbrq_pkg::S_EMIT_OUT;
            fbrq_pkg::S_EMIT_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = (r_got + SW'(1) == r_want) ? fbrq_pkg::S_IDLE
                                                         : fbrq_pkg::S_EMIT_RD;
                end
            end
            fbrq_pkg::S_STATUS: begin
                if (!r_ovalid || i_ready) begin
                    n_state = fbrq_pkg::S_IDLE;
                end
            end
            default: n_state = fbrq_pkg::S_IDLE;
        endcase
        if (i_cfg_we && i_cfg_index == fbrq_pkg::CFG_RING_LENGTH) begin
            n_state = fbrq_pkg::S_IDLE;
        end
    end

    always_comb begin
        n_rd = r_rd; n_wr = r_wr; n_full = r_full;
        n_scnt = r_scnt; n_sovf = r_sovf;
        n_left = r_left; n_want = r_want; n_got = r_got; n_idx = r_idx;
        n_hunt = r_hunt; n_pstart = r_pstart; n_eptr = r_eptr;
        n_ovalid = r_ovalid && !i_ready;
        n_obyte = r_obyte; n_olast = r_olast; n_ostat = r_ostat; n_oused = r_oused;
        ring_req = '{wr_en: 1'b0, addr: r_rd, wdata: 8'd0};
        stage_we = 1'b0;
        stage_addr = r_scnt[fbrq_pkg::StgAw-1:0];
        case (r_state)
            fbrq_pkg::S_IDLE: begin
                if (accept && i_req_type) begin
                    n_ostat = fbrq_pkg::ST_EMPTY;
                    n_oused = '0;
                    n_left  = used_now;
                    n_hunt  = fbrq_pkg::H_HUNT;
                    n_got   = '0;
                end else if (accept) begin
                    if (r_scnt < SW'(fbrq_pkg::PayloadMax)) begin
                        stage_we = 1'b1;
                        n_scnt = r_scnt + SW'(1);
                    end else begin
                        n_sovf = 1'b1;
                    end
                    if (i_last_byte) begin
                        n_idx = '0;
                        if (r_full) begin
                            n_ostat = fbrq_pkg::ST_FULL;
                        end else if (r_sovf || r_scnt == SW'(fbrq_pkg::PayloadMax)) begin
                            n_ostat = fbrq_pkg::ST_LEN_ERR;
                        end else if ({1'b0, r_rlen - used_now} <
                                     {1'b0, LW'(r_scnt) + LW'(fbrq_pkg::HeaderBytes + 1)}) begin
                            n_ostat = fbrq_pkg::ST_NOSPACE;
                        end else begin
                            n_ostat = fbrq_pkg::ST_OK;
                        end
                    end
                end
            end
            fbrq_pkg::S_COMMIT: begin
                stage_addr = fbrq_pkg::StgAw'(r_idx - (SW+2)'(2));
                if (r_ostat == fbrq_pkg::ST_OK && r_idx != r_total) begin
                    ring_req.wr_en = 1'b1;
                    ring_req.addr  = r_wr;
                    if (r_idx == '0) begin
                        ring_req.wdata = r_mark1;
                    end else if (r_idx == (SW+2)'(1)) begin
                        ring_req.wdata = r_mark2;
                    end else if (r_idx == (SW+2)'(2)) begin
                        ring_req.wdata = 8'(r_total);
                    end else begin
                        ring_req.wdata = stage_rdata;
                    end
                    n_wr  = nxt(r_wr, r_rlen);
                    n_idx = r_idx + (SW+2)'(1);
                    if (n_idx == r_total && n_wr == r_rd) begin
                        n_full = 1'b1;
                    end
                end
            end
            fbrq_pkg::S_SCAN_RD: begin
                ring_req.addr = r_rd;
            end
            fbrq_pkg::S_SCAN_CHK: begin
                n_rd   = nxt(r_rd, r_rlen);
                n_left = r_left - LW'(1);
                n_full = 1'b0;
                case (r_hunt)
                    fbrq_pkg::H_HUNT: begin
                        if (ring_rdata == r_mark1) n_hunt = fbrq_pkg::H_MARK1;
                    end
                    fbrq_pkg::H_MARK1: begin
                        if (ring_rdata == r_mark2) n_hunt = fbrq_pkg::H_MARK2;
                        else if (ring_rdata == r_mark1) n_hunt = fbrq_pkg::H_MARK1;
                        else n_hunt = fbrq_pkg::H_HUNT;
                    end
                    fbrq_pkg::H_MARK2: begin
                        if (ring_rdata >= 8'(fbrq_pkg::HeaderBytes + 1) &&
                            ring_rdata <= 8'(fbrq_pkg::MaxFrameBytes)) begin
                            n_want   = SW'(ring_rdata - 8'(fbrq_pkg::HeaderBytes));
                            n_got    = '0;
                            n_pstart = n_rd;
                            n_hunt   = fbrq_pkg::H_BODY;
                        end else if (ring_rdata == r_mark1) begin
                            n_hunt = fbrq_pkg::H_MARK1;
                        end else begin
                            n_hunt = fbrq_pkg::H_HUNT;
                        end
                    end
                    default: begin
                        n_got = r_got + SW'(1);
                    end
                endcase
                if (r_hunt == fbrq_pkg::H_BODY && n_got == r_want) begin
                    n_eptr = r_pstart;
                    n_got  = '0;
                end else if (r_left == LW'(1)) begin
                    n_ostat = fbrq_pkg::ST_NOITEM;
                    n_oused = '0;
                end
            end
            fbrq_pkg::S_EMIT_RD: begin
                ring_req.addr = r_eptr;
            end
            fbrq_pkg::S_EMIT_OUT: begin
                ring_req.addr = r_eptr;
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_obyte  = ring_rdata;
                    n_got    = r_got + SW'(1);
                    n_olast  = (n_got == r_want);
                    n_ostat  = fbrq_pkg::ST_OK;
                    n_oused  = used_now;
                    n_eptr   = nxt(r_eptr, r_rlen);
                end
            end
            fbrq_pkg::S_STATUS: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_obyte  = 8'd0;
                    n_olast  = 1'b1;
                    n_oused  = (r_ostat == fbrq_pkg::ST_EMPTY) ? '0 : used_now;
                    if (r_ostat != fbrq_pkg::ST_EMPTY && r_ostat != fbrq_pkg::ST_NOITEM) begin
                        n_scnt = '0;
                        n_sovf = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cfg_len = (i_cfg_data == 9'd0) ? 9'd1 : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbrq_pkg::S_IDLE;
            r_hunt  <= fbrq_pkg::H_HUNT;
            r_mark1 <= 8'd170;
            r_mark2 <= 8'd85;
            r_rlen  <= LW'(fbrq_pkg::RingDepth);
            r_rd <= '0; r_wr <= '0; r_full <= 1'b0;
            r_scnt <= '0; r_sovf <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hunt  <= n_hunt;
            r_rd <= n_rd; r_wr <= n_wr; r_full <= n_full;
            r_scnt <= n_scnt; r_sovf <= n_sovf;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fbrq_pkg::CFG_FIRST_MARK:  r_mark1 <= i_cfg_data[7:0];
                    fbrq_pkg::CFG_SECOND_MARK: r_mark2 <= i_cfg_data[7:0];
                    fbrq_pkg::CFG_RING_LENGTH: begin
                        r_rlen <= ({1'b0, cfg_len} > (LW+1)'(fbrq_pkg::RingDepth))
                                  ? LW'(fbrq_pkg::RingDepth) : LW'(cfg_len);
                        r_rd <= '0; r_wr <= '0; r_full <= 1'b0;
                        r_scnt <= '0; r_sovf <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left; r_want <= n_want; r_got <= n_got; r_idx <= n_idx;
        r_pstart <= n_pstart; r_eptr <= n_eptr;
        r_obyte <= n_obyte; r_olast <= n_olast; r_ostat <= n_ostat; r_oused <= n_oused;
        if (r_state == fbrq_pkg::S_IDLE) begin
            r_total <= (SW+2)'(n_scnt) + (SW+2)'(fbrq_pkg::HeaderBytes);
        end
    end

    `ASSERT_NEVER(a_ready_busy, i_clk, i_rst_n, o_ready && r_state != fbrq_pkg::S_IDLE, "ready while busy")
    `ASSERT_NEVER(a_used_range, i_clk, i_rst_n, used_now > r_rlen, "used exceeds ring length")
    `ASSERT_CLK(a_full_ptrs, i_clk, i_rst_n, !r_full || r_rd == r_wr, "full with unequal pointers")
    `ASSERT_NEVER(a_stage_cnt, i_clk, i_rst_n, r_scnt > SW'(fbrq_pkg::PayloadMax), "stage overrun")

endmodule
